// ===== rtl/fastq_gc_content_top_defines.svh =====
// Assertion macros used by the GC-content meter controller.
`ifndef FASTQ_GC_CONTENT_TOP_DEFINES_SVH
`define FASTQ_GC_CONTENT_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define FGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define FGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fgc_pkg.sv =====
// Shared types and constants of the GC-content meter.
`default_nettype none
package fgc_pkg;

  localparam int unsigned RD_BITS = 32;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_LG = 8'h67;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_LC = 8'h63;

  typedef struct packed {
    logic take_byte;
    logic start_frac;
    logic zero_frac;
    logic latch_frac;
    logic post;
    logic start_mean;
    logic load_out;
    logic final_out;
    logic use_mean;
  } fgc_cmd_t;

  typedef struct packed {
    logic rec_end;
    logic base_zero;
    logic div_done;
    logic last;
    logic n_zero;
    logic out_full;
  } fgc_status_t;

endpackage
`default_nettype wire

// ===== rtl/fastq_gc_content_top.sv =====
// Top level of the streaming FASTQ GC-content meter.
// Usage:
//   in_*  : one FASTQ text byte per transaction (in_valid / in_stall).
//   out_* : one result per completed record (out_valid / out_stall), carrying
//           the GC and base counts, the Q1.FRAC_BITS GC fraction, the empty
//           flag, and on the last record the mean fraction and final flag.
//   cfg_* : writes read_target; cfg_ready is always high. Write only when idle.
// Throughput: one byte per cycle while in_stall is low. The newline closing a
//   record holds off further bytes while the divider runs FRAC_BITS+1 steps
//   and the fraction is latched and posted, or only while it is posted for an
//   empty read; the final record adds the mean on the serial divider.
// Result: after the closing newline is taken, the fraction is divided (S_FRAC,
//   skipped for an empty read) and latched, and S_POST loads the result; on the
//   final record S_POST starts the mean division and S_MEAN loads the result.
// Reset (rst_n, synchronous): clears all counts and sets read_target to 1.
// Stall: while a result waits, bytes keep flowing; only the next record's
//   closing newline is held off until the result is taken. After the final
//   record every byte is taken and dropped until reset.
`default_nettype none
module fastq_gc_content_top #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_text_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COUNT_BITS-1:0]      out_gc_bases,
  output logic [COUNT_BITS-1:0]      out_seq_length,
  output logic [FRAC_BITS:0]         out_gc_fraction,
  output logic                       out_empty_read,
  output logic [FRAC_BITS:0]         out_mean_fraction,
  output logic                       out_final_record,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [31:0]           cfg_read_target
);
  import fgc_pkg::*;

  fgc_cmd_t    cmd;
  fgc_status_t status;

  assign cfg_ready = 1'b1;

  fgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  fgc_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_text_byte      (in_text_byte),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_read_target   (cfg_read_target),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gc_bases      (out_gc_bases),
    .out_seq_length    (out_seq_length),
    .out_gc_fraction   (out_gc_fraction),
    .out_empty_read    (out_empty_read),
    .out_mean_fraction (out_mean_fraction),
    .out_final_record  (out_final_record)
  );

endmodule
`default_nettype wire

// ===== rtl/fgc_divider.sv =====
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module fgc_divider #(
  parameter int unsigned DEN_W = 32,
  parameter int unsigned DVD_W = 49,
  parameter int unsigned CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] init_rem,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [CNT_W-1:0] steps,
  output logic                  done,
  output logic      [DVD_W-1:0] quo
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, dvd_r[DVD_W-1]};
    ge       = shifted >= {1'b0, den_r};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = init_rem;
      dvd_nxt  = dvd;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/fgc_datapath.sv =====
// Byte decode, tallies, running sum, output register and divider of the meter.
`default_nettype none
module fgc_datapath #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  cfg_write,
  input  wire logic [31:0]           cfg_read_target,
  input  wire fgc_pkg::fgc_cmd_t     cmd,
  output fgc_pkg::fgc_status_t       status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COUNT_BITS-1:0]      out_gc_bases,
  output logic [COUNT_BITS-1:0]      out_seq_length,
  output logic [FRAC_BITS:0]         out_gc_fraction,
  output logic                       out_empty_read,
  output logic [FRAC_BITS:0]         out_mean_fraction,
  output logic                       out_final_record
);
  import fgc_pkg::*;

  localparam int unsigned SUM_BITS = RD_BITS + FRAC_BITS + 1;
  localparam int unsigned DEN_W    = (COUNT_BITS > RD_BITS) ? COUNT_BITS : RD_BITS;
  localparam int unsigned CNT_W    = $clog2(SUM_BITS + 1);

  logic [31:0]           target_r;
  logic [1:0]            phase_r, phase_nxt;
  logic                  cut_r, cut_nxt;
  logic [COUNT_BITS-1:0] gc_r, gc_nxt;
  logic [COUNT_BITS-1:0] base_r, base_nxt;
  logic [RD_BITS-1:0]    rd_r;
  logic [SUM_BITS-1:0]   sum_r;
  logic                  out_valid_r;

  logic [COUNT_BITS-1:0] out_gc_r;
  logic [COUNT_BITS-1:0] out_len_r;
  logic [FRAC_BITS:0]    out_frac_r;
  logic                  out_empty_r;
  logic [FRAC_BITS:0]    out_mean_r;
  logic                  out_final_r;

  logic                  is_gc;
  logic [RD_BITS-1:0]    n_cur;
  logic [SUM_BITS-1:0]   sum_nxt;
  logic [SUM_BITS-1:0]   mean_dvd;
  logic [FRAC_BITS+1:0]  frac_inc;
  logic                  div_start;
  logic [DEN_W-1:0]      div_rem;
  logic [SUM_BITS-1:0]   div_dvd;
  logic [DEN_W-1:0]      div_den;
  logic [CNT_W-1:0]      div_steps;
  logic                  div_done;
  logic [SUM_BITS-1:0]   div_quo;

  always_comb begin
    is_gc     = in_text_byte inside {CH_G, CH_LG, CH_C, CH_LC};
    phase_nxt = phase_r;
    cut_nxt   = cut_r;
    gc_nxt    = gc_r;
    base_nxt  = base_r;
    if (cmd.take_byte) begin
      if (in_text_byte == CH_LF) begin
        cut_nxt   = 1'b0;
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          gc_nxt   = '0;
          base_nxt = '0;
        end
      end else if (in_text_byte == CH_CR) begin
        cut_nxt = 1'b1;
      end else if (!cut_r && phase_r == 2'd1) begin
        if (base_r != '1) base_nxt = base_r + COUNT_BITS'(1);
        if (is_gc && gc_r != '1) gc_nxt = gc_r + COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    n_cur    = rd_r + RD_BITS'(1);
    sum_nxt  = sum_r + SUM_BITS'(out_frac_r);
    mean_dvd = sum_nxt + SUM_BITS'(n_cur >> 1);
    frac_inc = {1'b0, div_quo[FRAC_BITS:0]} + (FRAC_BITS+2)'(1);

    div_start = cmd.start_frac || cmd.start_mean;
    div_rem   = cmd.start_frac ? DEN_W'(gc_r) : '0;
    div_dvd   = cmd.start_frac ? '0 : mean_dvd;
    div_den   = cmd.start_frac ? DEN_W'(base_r) : DEN_W'(n_cur);
    div_steps = cmd.start_frac ? CNT_W'(FRAC_BITS + 1) : CNT_W'(SUM_BITS);

    status.rec_end   = in_valid && in_text_byte == CH_LF && phase_r == 2'd3;
    status.base_zero = base_r == '0;
    status.div_done  = div_done;
    status.last      = n_cur >= target_r;
    status.n_zero    = n_cur == '0;
    status.out_full  = out_valid_r;
  end

  fgc_divider #(
    .DEN_W (DEN_W),
    .DVD_W (SUM_BITS),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .init_rem (div_rem),
    .dvd      (div_dvd),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= 32'd1;
      phase_r     <= '0;
      cut_r       <= 1'b0;
      gc_r        <= '0;
      base_r      <= '0;
      rd_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) target_r <= cfg_read_target;
      phase_r <= phase_nxt;
      cut_r   <= cut_nxt;
      gc_r    <= gc_nxt;
      base_r  <= base_nxt;
      if (cmd.post) begin
        rd_r  <= n_cur;
        sum_r <= sum_nxt;
      end
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && status.rec_end) begin
      out_gc_r    <= gc_r;
      out_len_r   <= base_r;
      out_empty_r <= base_r == '0;
    end
    if (cmd.zero_frac) out_frac_r <= '0;
    else if (cmd.latch_frac) out_frac_r <= frac_inc[FRAC_BITS+1:1];
    if (cmd.load_out) begin
      out_mean_r  <= cmd.use_mean ? div_quo[FRAC_BITS:0] : '0;
      out_final_r <= cmd.final_out;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gc_bases      = out_gc_r;
  assign out_seq_length    = out_len_r;
  assign out_gc_fraction   = out_frac_r;
  assign out_empty_read    = out_empty_r;
  assign out_mean_fraction = out_mean_r;
  assign out_final_record  = out_final_r;

endmodule
`default_nettype wire

// ===== rtl/fgc_ctrl.sv =====
// Controller state machine of the GC-content meter.
`default_nettype none
`include "fastq_gc_content_top_defines.svh"
module fgc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire fgc_pkg::fgc_status_t status,
  output logic                      in_stall,
  output fgc_pkg::fgc_cmd_t         cmd
);
  import fgc_pkg::*;

  typedef enum logic [4:0] {
    S_SCAN = 5'b00001,
    S_FRAC = 5'b00010,
    S_POST = 5'b00100,
    S_MEAN = 5'b01000,
    S_DONE = 5'b10000
  } fgc_state_t;

  fgc_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_SCAN: begin
        // hold a record end until the previous result has been taken
        in_stall      = status.rec_end && status.out_full;
        cmd.take_byte = in_valid && !in_stall;
        if (cmd.take_byte && status.rec_end) begin
          if (status.base_zero) begin
            cmd.zero_frac = 1'b1;
            state_nxt     = S_POST;
          end else begin
            cmd.start_frac = 1'b1;
            state_nxt      = S_FRAC;
          end
        end
      end
      S_FRAC: begin
        if (status.div_done) begin
          cmd.latch_frac = 1'b1;
          state_nxt      = S_POST;
        end
      end
      S_POST: begin
        cmd.post = 1'b1;
        if (status.last && !status.n_zero) begin
          cmd.start_mean = 1'b1;
          state_nxt      = S_MEAN;
        end else begin
          cmd.load_out  = 1'b1;
          cmd.final_out = status.last;
          state_nxt     = status.last ? S_DONE : S_SCAN;
        end
      end
      S_MEAN: begin
        if (status.div_done) begin
          cmd.load_out  = 1'b1;
          cmd.final_out = 1'b1;
          cmd.use_mean  = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        in_stall = 1'b0;
      end
      default: begin
        state_nxt = S_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  `FGC_ASSERT_NOW(a_stall_busy, (state_r == S_FRAC) || (state_r == S_POST) || (state_r == S_MEAN), in_stall, "byte taken while a record is being finished")
  `FGC_ASSERT_NOW(a_done_state, status.div_done, (state_r == S_FRAC) || (state_r == S_MEAN), "divider finished outside a divide state")
  `FGC_ASSERT_NOW(a_out_free, cmd.load_out, !status.out_full, "result loaded over an untaken result")
  `FGC_ASSERT_NEXT(a_done_sticky, state_r == S_DONE, state_r == S_DONE, "left finished state without reset")

endmodule
`default_nettype wire
